// ----- rtl/scpm_pkg.sv -----
// Types and constants shared by the sinogram crystal pair map.
package scpm_pkg;

   localparam int MAX_RING_CRYSTALS_DEFAULT = 4096;

   // widths of the configuration fields and derived ring quantities
   localparam int BLOCKS_W  = 8;
   localparam int CPB_W     = 6;
   localparam int PROJ_W    = 11;
   localparam int NX_W      = BLOCKS_W + CPB_W;
   localparam int NA_W      = NX_W - 1;
   localparam int INDEX_W   = 11;
   localparam int CRYSTAL_W = 12;
   localparam int POS_W     = 22;
   // signed working width for crystal arithmetic, holds up to twice the ring size
   localparam int CALC_W    = NX_W + 3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = PROJ_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DETECTOR_BLOCKS       = 3'd0,
      CSR_CRYSTALS_PER_BLOCK    = 3'd1,
      CSR_PROJECTIONS_PER_ANGLE = 3'd2,
      CSR_COMPRESSION_ON        = 3'd3,
      CSR_HALF_BLOCK_SHIFT      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_ODD_BLOCKS   = 2'd1,
      STATUS_TOO_MANY     = 2'd2,
      STATUS_OUT_OF_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [INDEX_W-1:0] angle_index;
      logic [INDEX_W-1:0] projection_index;
   } req_payload_type;

   typedef struct packed {
      logic [CRYSTAL_W-1:0] crystal_first;
      logic [CRYSTAL_W-1:0] crystal_second;
      logic                 bin_kept;
      logic [POS_W-1:0]     table_position;
      status_type           status;
   } rsp_payload_type;

endpackage

// ----- rtl/sinogram_crystal_pair_map.sv -----
// Top level of the sinogram crystal pair map: bin to crystal pair lookup.
//
// Maps one sinogram bin (angle, projection) to the two ring crystals bounding
// its line of response, plus its row-major place in the full or compressed
// table and whether it is kept. One transaction per clock is sustained while
// the result is not stalled; an accepted transaction is held in the input
// register, one pass of arithmetic loads the result register, and the result
// leaves from there. A stalled result holds the input register, which then
// stalls the input. Ring geometry terms are worked out
// from the configuration registers into a register bank the cycle after a
// write, so the per-bin path holds only adds, compares and one 11x11 multiply
// for the table position. Configuration errors are reported in the status
// field of every result, with all other fields zero.
module sinogram_crystal_pair_map
   import scpm_pkg::*;
#(
   parameter int MAX_RING_CRYSTALS = MAX_RING_CRYSTALS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload
);

   // configuration registers
   logic [BLOCKS_W-1:0] detector_blocks_ff;
   logic [CPB_W-1:0]    crystals_per_block_ff;
   logic [PROJ_W-1:0]   projections_per_angle_ff;
   logic                compression_on_ff;
   logic                half_block_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         detector_blocks_ff       <= BLOCKS_W'(2);
         crystals_per_block_ff    <= CPB_W'(1);
         projections_per_angle_ff <= PROJ_W'(1);
         compression_on_ff        <= 1'b0;
         half_block_shift_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DETECTOR_BLOCKS:       detector_blocks_ff <= csr_write_data[BLOCKS_W-1:0];
            CSR_CRYSTALS_PER_BLOCK:    crystals_per_block_ff <= csr_write_data[CPB_W-1:0];
            CSR_PROJECTIONS_PER_ANGLE: projections_per_angle_ff <= csr_write_data[PROJ_W-1:0];
            CSR_COMPRESSION_ON:        compression_on_ff <= csr_write_data[0];
            CSR_HALF_BLOCK_SHIFT:      half_block_shift_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // ring geometry derived from configuration
   logic [NX_W-1:0]          nx_in, nx_ff;
   logic [NA_W-1:0]          na_in, na_ff;
   logic [PROJ_W-1:0]        nb_in, nb_ff;
   logic [PROJ_W-2:0]        nb_half_in, nb_half_ff;
   logic [NA_W-1:0]          nac_in, nac_ff;
   logic signed [CALC_W-1:0] m_base_in, m_base_ff;
   logic signed [CALC_W-1:0] a_base_in, a_base_ff;
   logic signed [CALC_W-1:0] b_base_in, b_base_ff;
   status_type               cfg_status_in, cfg_status_ff;

   logic signed [CALC_W-1:0] na_even, nr, nr_half, list_size, cpb_half, na_s;

   always_comb begin
      nx_in      = NX_W'(detector_blocks_ff) * NX_W'(crystals_per_block_ff);
      na_in      = nx_in[NX_W-1:1];
      nb_in      = projections_per_angle_ff | PROJ_W'(1);
      nb_half_in = nb_in[PROJ_W-1:1];
      na_s       = CALC_W'(signed'({1'b0, na_in}));
      na_even    = CALC_W'(signed'({1'b0, na_in[NA_W-1:1], 1'b0}));
      cpb_half   = CALC_W'(signed'({1'b0, crystals_per_block_ff[CPB_W-1:1]}));
      if (half_block_shift_ff) begin
         nr = na_even - CALC_W'(2);
      end else if (crystals_per_block_ff[0]) begin
         nr = na_even - CALC_W'(1);
      end else begin
         nr = na_even;
      end
      nr_half   = nr >>> 1;
      list_size = (nr >= CALC_W'(1)) ? ((nr <<< 1) - CALC_W'(1)) : '0;
      // list size is odd, so its half is nr - 1
      m_base_in = nr - CALC_W'(1) - CALC_W'(signed'({1'b0, nb_half_in}));
      if (half_block_shift_ff) begin
         a_base_in = nr_half - CALC_W'(1);
         b_base_in = na_s - nr_half;
      end else if (crystals_per_block_ff[0]) begin
         a_base_in = cpb_half + nr_half;
         b_base_in = na_s + cpb_half - nr_half;
      end else begin
         a_base_in = cpb_half + nr_half - CALC_W'(1);
         b_base_in = na_s + cpb_half - nr_half;
      end
      // compressed angle count; na >= 2 whenever the configuration is usable
      if (detector_blocks_ff[1:0] == 2'b00) begin
         nac_in = NA_W'(na_in >> 2) + NA_W'(1);
      end else begin
         nac_in = NA_W'(na_in >> 1) + NA_W'(1);
      end
      if (detector_blocks_ff[0]) begin
         cfg_status_in = STATUS_ODD_BLOCKS;
      end else if (list_size < CALC_W'(signed'({1'b0, nb_in}))
                   || 32'(nx_in) > 32'(MAX_RING_CRYSTALS)) begin
         cfg_status_in = STATUS_TOO_MANY;
      end else begin
         cfg_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_status_ff <= STATUS_OK;
      end else begin
         cfg_status_ff <= cfg_status_in;
      end
      nx_ff      <= nx_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      nb_half_ff <= nb_half_in;
      nac_ff     <= nac_in;
      m_base_ff  <= m_base_in;
      a_base_ff  <= a_base_in;
      b_base_ff  <= b_base_in;
   end

   // pipeline control
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_payload_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            out_load, s1_load;

   always_comb begin
      out_load     = !rsp_valid_ff || !rsp_stall;
      s1_load      = !s1_valid_ff || out_load;
      req_stall    = !s1_load;
      s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_load && req_valid) begin
         s1_payload_ff <= req_payload;
      end
      if (out_load && s1_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // per-bin arithmetic
   logic signed [CALC_W-1:0] ai_s, pj_s, nx_s, m, c, a_raw, a_fix, a_sum, b_raw, b_sum;
   logic [CALC_W-1:0]        a_wrap, b_wrap;
   logic                     range_bad, kept;
   logic [PROJ_W-1:0]        pos_mult;
   logic [POS_W:0]           pos_sum;
   status_type               item_status;

   always_comb begin
      ai_s  = CALC_W'(signed'({1'b0, s1_payload_ff.angle_index}));
      pj_s  = CALC_W'(signed'({1'b0, s1_payload_ff.projection_index}));
      nx_s  = CALC_W'(signed'({1'b0, nx_ff}));
      range_bad = (NA_W'(s1_payload_ff.angle_index) >= na_ff)
                  || (s1_payload_ff.projection_index >= nb_ff);
      m     = m_base_ff + pj_s;
      c     = m >>> 1;
      a_raw = a_base_ff - c;
      a_fix = (a_raw < 0) ? (a_raw + nx_s) : a_raw;
      a_sum = a_fix + ai_s;
      b_raw = b_base_ff + c + CALC_W'(signed'({1'b0, m[0]}));
      b_sum = b_raw + ai_s;
      // both sums stay below twice the ring size: one subtract wraps them
      a_wrap = unsigned'((a_sum >= nx_s) ? (a_sum - nx_s) : a_sum);
      b_wrap = unsigned'((b_sum >= nx_s) ? (b_sum - nx_s) : b_sum);

      if (compression_on_ff) begin
         pos_mult = PROJ_W'(nb_half_ff) + PROJ_W'(1);
         kept     = ({1'b0, s1_payload_ff.angle_index} < (INDEX_W+1)'(nac_ff))
                    && (s1_payload_ff.projection_index <= INDEX_W'(nb_half_ff));
      end else begin
         pos_mult = nb_ff;
         kept     = 1'b1;
      end
      pos_sum = (POS_W+1)'(POS_W'(s1_payload_ff.angle_index) * POS_W'(pos_mult))
                + (POS_W+1)'(s1_payload_ff.projection_index);

      if (cfg_status_ff != STATUS_OK) begin
         item_status = cfg_status_ff;
      end else if (range_bad) begin
         item_status = STATUS_OUT_OF_RANGE;
      end else begin
         item_status = STATUS_OK;
      end

      rsp_payload_in = '0;
      rsp_payload_in.status = item_status;
      if (item_status == STATUS_OK) begin
         rsp_payload_in.crystal_first  = a_wrap[CRYSTAL_W-1:0];
         rsp_payload_in.crystal_second = b_wrap[CRYSTAL_W-1:0];
         rsp_payload_in.bin_kept       = kept;
         rsp_payload_in.table_position = kept ? pos_sum[POS_W-1:0] : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // assertions
   a_error_zeroes_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_OK) |->
      (rsp_payload.crystal_first == '0 && rsp_payload.crystal_second == '0
       && !rsp_payload.bin_kept && rsp_payload.table_position == '0))
      else $error("error result carries nonzero fields");

   a_dropped_bin_no_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.bin_kept) |-> (rsp_payload.table_position == '0))
      else $error("bin not kept but position nonzero");

   a_full_table_keeps_all: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_load && !compression_on_ff && item_status == STATUS_OK)
      |=> rsp_payload.bin_kept)
      else $error("full table dropped a bin");

   a_full_pipe_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input accepted while pipeline full and blocked");

endmodule

// ----- test/tb_sinogram_crystal_pair_map.sv -----
// Self-checking testbench for the sinogram crystal pair map lookup.
module tb_sinogram_crystal_pair_map;
   timeunit 1ns;
   timeprecision 1ps;
   import scpm_pkg::*;

   localparam longint IDX_MAX = (1 << INDEX_W) - 1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;

   // shadow copy of the geometry registers
   logic [BLOCKS_W-1:0] cfg_blocks = 8'd2;
   logic [CPB_W-1:0]    cfg_cpb = 6'd1;
   logic [PROJ_W-1:0]   cfg_proj = 11'd1;
   logic                cfg_comp = 1'b0;
   logic                cfg_half = 1'b0;

   req_payload_type bin_pending[$];
   rsp_payload_type pair_expect[$];
   int  bins_queued = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  settings_run = 1;
   int  status_seen[4] = '{default: 0};
   int  kept_seen = 0;
   bit  no_idle = 1'b0;

   sinogram_crystal_pair_map i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   always #2ns clock = ~clock;

   // angles, odd projection count and compressed angle count of the current ring
   function automatic void ring_shape(output longint na, output longint nb,
                                      output longint nac);
      na = (longint'(cfg_blocks) * longint'(cfg_cpb)) / 2;
      nb = longint'(cfg_proj | 11'd1);
      nac = (cfg_blocks % 4 == 0) ? na / 4 + 1 : (na - 2) / 2 + 2;
   endfunction

   function automatic rsp_payload_type predict_pair(req_payload_type bin);
      longint nblk, cpb, nx, na, nb, nac, ai, pj, nr, span, m, c, a, b, pos;
      rsp_payload_type res;
      ring_shape(na, nb, nac);
      nblk = longint'(cfg_blocks);
      cpb = longint'(cfg_cpb);
      nx = nblk * cpb;
      ai = longint'(bin.angle_index);
      pj = longint'(bin.projection_index);
      res = '0;
      res.status = STATUS_OK;
      if (nblk % 2 != 0) begin
         res.status = STATUS_ODD_BLOCKS;
         return res;
      end
      if (cfg_half) nr = na / 2 * 2 - 2;
      else if (cpb % 2 != 0) nr = na / 2 * 2 - 1;
      else nr = na / 2 * 2;
      span = (nr >= 1) ? 2 * nr - 1 : 0;
      if (span < nb || nx > MAX_RING_CRYSTALS_DEFAULT) begin
         res.status = STATUS_TOO_MANY;
         return res;
      end
      if (ai >= na || pj >= nb) begin
         res.status = STATUS_OUT_OF_RANGE;
         return res;
      end
      // central nb pairs of the angle-zero candidate list
      m = span / 2 - nb / 2 + pj;
      c = m / 2;
      if (cfg_half) begin
         a = nr / 2 - c - 1;
         b = na - nr / 2 + c + (m % 2);
      end else if (cpb % 2 != 0) begin
         a = cpb / 2 + nr / 2 - c;
         b = na + cpb / 2 - nr / 2 + c + (m % 2);
      end else begin
         a = cpb / 2 + nr / 2 - 1 - c;
         b = na + cpb / 2 - nr / 2 + c + (m % 2);
      end
      if (a < 0) a += nx;
      a = (a + ai) % nx;
      b = (b + ai) % nx;
      if (cfg_comp) begin
         if (ai < nac && pj <= nb / 2) begin
            res.bin_kept = 1'b1;
            pos = ai * (nb / 2 + 1) + pj;
         end else begin
            pos = 0;
         end
      end else begin
         res.bin_kept = 1'b1;
         pos = ai * nb + pj;
      end
      res.crystal_first = a[CRYSTAL_W-1:0];
      res.crystal_second = b[CRYSTAL_W-1:0];
      res.table_position = pos[POS_W-1:0];
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            pair_expect.insert(pair_expect.size(), predict_pair(req_payload));
         if (!req_valid || !req_stall) begin
            if (bin_pending.size() != 0 && (no_idle || $urandom_range(99, 0) >= 25)) begin
               req_valid <= 1'b1;
               req_payload <= bin_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pair_expect.size() == 0) begin
               $error("unexpected transaction on the result channel");
               mismatches++;
            end else begin
               want = pair_expect.pop_front();
               status_seen[want.status]++;
               if (want.bin_kept) kept_seen++;
               if (rsp_payload.crystal_first !== want.crystal_first) begin
                  $error("crystal_first: expected %0d, actual %0d",
                         want.crystal_first, rsp_payload.crystal_first);
                  mismatches++;
               end
               if (rsp_payload.crystal_second !== want.crystal_second) begin
                  $error("crystal_second: expected %0d, actual %0d",
                         want.crystal_second, rsp_payload.crystal_second);
                  mismatches++;
               end
               if (rsp_payload.bin_kept !== want.bin_kept) begin
                  $error("bin_kept: expected %0d, actual %0d",
                         want.bin_kept, rsp_payload.bin_kept);
                  mismatches++;
               end
               if (rsp_payload.table_position !== want.table_position) begin
                  $error("table_position: expected %0d, actual %0d",
                         want.table_position, rsp_payload.table_position);
                  mismatches++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_payload.status);
                  mismatches++;
               end
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99, 0) < 25);
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_DETECTOR_BLOCKS:       cfg_blocks = data[BLOCKS_W-1:0];
         CSR_CRYSTALS_PER_BLOCK:    cfg_cpb = data[CPB_W-1:0];
         CSR_PROJECTIONS_PER_ANGLE: cfg_proj = data[PROJ_W-1:0];
         CSR_COMPRESSION_ON:        cfg_comp = data[0];
         CSR_HALF_BLOCK_SHIFT:      cfg_half = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random junk above the register's own width
   function automatic logic [CSR_DATA_W-1:0] with_noise(int value, int w);
      logic [CSR_DATA_W-1:0] mask, junk;
      mask = (CSR_DATA_W'(1) << w) - 1'b1;
      junk = CSR_DATA_W'($urandom);
      return (junk & ~mask) | (CSR_DATA_W'(value) & mask);
   endfunction

   task automatic apply_setting(int blocks, int cpb, int proj, bit comp, bit half);
      write_csr(CSR_DETECTOR_BLOCKS, with_noise(blocks, BLOCKS_W));
      write_csr(CSR_CRYSTALS_PER_BLOCK, with_noise(cpb, CPB_W));
      write_csr(CSR_PROJECTIONS_PER_ANGLE, with_noise(proj, PROJ_W));
      write_csr(CSR_COMPRESSION_ON, with_noise(comp, 1));
      write_csr(CSR_HALF_BLOCK_SHIFT, with_noise(half, 1));
      // unmapped indexes must leave the geometry alone
      for (int k = int'(CSR_HALF_BLOCK_SHIFT) + 1; k < (1 << CSR_INDEX_W); k++)
         write_csr(k[CSR_INDEX_W-1:0], CSR_DATA_W'($urandom));
      // let the derived geometry settle
      repeat (3) @(posedge clock);
      settings_run++;
   endtask

   task automatic push_bin(longint a, longint p);
      req_payload_type bin;
      bin.angle_index = (a < 0) ? '0 : (a > IDX_MAX) ? INDEX_W'(IDX_MAX) : a[INDEX_W-1:0];
      bin.projection_index = (p < 0) ? '0 : (p > IDX_MAX) ? INDEX_W'(IDX_MAX)
                                                          : p[INDEX_W-1:0];
      bin_pending.insert(bin_pending.size(), bin);
      bins_queued++;
   endtask

   task automatic queue_bins(int n, bit corners);
      longint na, nb, nac, lim, ai, pj;
      int sel;
      ring_shape(na, nb, nac);
      lim = (na > IDX_MAX + 1) ? IDX_MAX + 1 : na;
      if (corners) begin
         push_bin(0, 0);
         push_bin(na - 1, nb - 1);
         push_bin(0, nb / 2);
         push_bin(nac - 1, nb / 2);
         push_bin(nac, nb / 2 + 1);
         push_bin(na, 0);
         push_bin(0, nb);
         push_bin(IDX_MAX, IDX_MAX);
      end
      repeat (n) begin
         sel = $urandom_range(99, 0);
         if (sel < 80 && lim > 0) begin
            if (cfg_comp && sel < 40) begin
               ai = longint'($urandom_range(int'(((nac < lim) ? nac : lim) - 1), 0));
               pj = longint'($urandom_range(int'(nb / 2), 0));
            end else begin
               ai = longint'($urandom_range(int'(lim - 1), 0));
               pj = longint'($urandom_range(int'(nb - 1), 0));
            end
         end else if (sel < 90 && lim > 0) begin
            if (sel < 85 && lim <= IDX_MAX) begin
               ai = longint'($urandom_range(int'(IDX_MAX), int'(lim)));
               pj = longint'($urandom_range(int'(nb - 1), 0));
            end else begin
               ai = longint'($urandom_range(int'(lim - 1), 0));
               pj = longint'($urandom_range(int'(IDX_MAX), int'(nb)));
            end
         end else begin
            ai = longint'($urandom_range(int'(IDX_MAX), 0));
            pj = longint'($urandom_range(int'(IDX_MAX), 0));
         end
         push_bin(ai, pj);
      end
      while (results_seen < bins_queued) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_bins(40, 1'b0);
      apply_setting(16, 8, 15, 1, 0);
      queue_bins(100, 1'b1);
      apply_setting(18, 7, 20, 1, 1);
      queue_bins(100, 1'b1);
      // largest ring, back to back on both sides
      apply_setting(128, 32, 2047, 1, 0);
      no_idle = 1'b1;
      queue_bins(100, 1'b1);
      no_idle = 1'b0;
      apply_setting(128, 32, 2047, 0, 1);
      queue_bins(100, 1'b0);
      apply_setting(12, 6, 11, 0, 1);
      queue_bins(100, 1'b0);
      apply_setting(4, 1, 1, 0, 0);
      queue_bins(80, 1'b0);
      apply_setting(2, 1, 1, 1, 1);
      queue_bins(40, 1'b0);
      apply_setting(7, 4, 5, 0, 0);
      queue_bins(40, 1'b0);
      apply_setting(255, 63, 2047, 1, 1);
      queue_bins(30, 1'b0);
      apply_setting(0, 0, 0, 0, 0);
      queue_bins(30, 1'b0);
      apply_setting(128, 40, 9, 0, 0);
      queue_bins(40, 1'b0);
      apply_setting(2, 20, 50, 0, 0);
      queue_bins(40, 1'b0);
      apply_setting(64, 3, 200, 1, 1);
      queue_bins(100, 1'b0);
      apply_setting(100, 33, 1000, 1, 0);
      queue_bins(100, 1'b0);
      apply_setting(30, 9, 99, 1, 0);
      queue_bins(100, 1'b0);
      apply_setting(40, 2, 38, 0, 0);
      queue_bins(100, 1'b0);
      apply_setting(2, 2, 2, 1, 0);
      queue_bins(60, 1'b0);
      apply_setting(6, 1, 4, 1, 1);
      queue_bins(40, 1'b0);
      apply_setting(24, 16, 383, 1, 0);
      queue_bins(100, 1'b0);

      repeat (8) @(posedge clock);
      if (pair_expect.size() != 0) begin
         $error("%0d crystal pairs never came back", pair_expect.size());
         mismatches++;
      end
      $display("Looked up %0d bins over %0d ring settings; %0d kept.",
               results_seen, settings_run, kept_seen);
      $display("Status ok/odd/too many/out of range: %0d/%0d/%0d/%0d.",
               status_seen[STATUS_OK], status_seen[STATUS_ODD_BLOCKS],
               status_seen[STATUS_TOO_MANY], status_seen[STATUS_OUT_OF_RANGE]);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sinogram_crystal_pair_map.f -----
rtl/scpm_pkg.sv
rtl/sinogram_crystal_pair_map.sv
test/tb_sinogram_crystal_pair_map.sv
